// ===== design/line_and_color_sensor_fusion_defines.svh =====
// ----------------------------------------------------------------------------
// Line and color sensor fusion: assertion macros
// Shared assertion helpers. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef LINE_AND_COLOR_SENSOR_FUSION_DEFINES_SVH
`define LINE_AND_COLOR_SENSOR_FUSION_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LCSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LCSF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LCSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== design/lcsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Line and color sensor fusion package
// Fixed constants, classifier coefficients and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsf_pkg;

  // Calibration register file.
  localparam int NUM_LEVELS  = 8;
  localparam int LEVEL_IDX_W = 3;
  localparam int unsigned LEVEL_RESET [NUM_LEVELS] = '{35, 350, 45, 400, 42, 342, 36, 360};

  // Number of photodiodes and of color channels.
  localparam int NUM_DIODES = 4;
  localparam int NUM_RATIOS = 3;

  // Output field widths.
  localparam int POS_W      = 15;
  localparam int WID_W      = 15;
  localparam int COLOR_W    = 3;
  localparam int OUT_DATA_W = 40;

  // Color ratio scaling: count * 100 in Q8.8, saturated to 16 bits.
  localparam int RATIO_W     = 16;
  localparam int SCALE_W     = 15;
  localparam int RATIO_SCALE = 25600;
  localparam int RATIO_MAX   = 65535;

  // White channel darkness levels.
  localparam int WLEVEL_W          = 15;
  localparam int COLOR_BLACK_LEVEL = 11000;
  localparam int COLOR_WHITE_LEVEL = 20000;
  localparam int SPAN_W            = 14;
  localparam int COLOR_SPAN        = COLOR_WHITE_LEVEL - COLOR_BLACK_LEVEL;

  // Classifier coefficients, scaled by one million.
  localparam int NUM_CLASSES = 5;
  localparam int NUM_TERMS   = 4;
  localparam int WGT_W       = 22;
  localparam int BIAS_W      = 27;
  localparam int BIAS_SHIFT  = 8;

  localparam logic signed [WGT_W-1:0] CLASS_WEIGHT [NUM_CLASSES][NUM_TERMS] = '{
    '{-22'sd215193,  22'sd158631,  22'sd447248,  22'sd700},
    '{-22'sd478091, -22'sd265669,  22'sd986931, -22'sd1539},
    '{ 22'sd355452, -22'sd928157, -22'sd255726,  22'sd547},
    '{-22'sd102398,  22'sd391205, -22'sd465644, -22'sd426},
    '{ 22'sd440230,  22'sd643990, -22'sd712809,  22'sd718}
  };

  localparam logic signed [BIAS_W-1:0] CLASS_BIAS [NUM_CLASSES] = '{
    -27'sd24586008, 27'sd21651707, 27'sd32428762, 27'sd10497819, -27'sd39992280
  };

  // Surface color classes.
  typedef enum logic [COLOR_W-1:0] {
    SURF_WHITE = 3'd0,
    SURF_BLACK = 3'd1,
    SURF_RED   = 3'd2,
    SURF_GREEN = 3'd3,
    SURF_BLUE  = 3'd4
  } color_e;

endpackage

`default_nettype wire

// ===== design/lcsf_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The caller keeps
// the numerator below the divisor shifted up by the quotient width.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsf_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 10,
  parameter int QUO_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quo_o
);

  localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [REM_W-1:0] rem_q [QUO_W-1];
  logic [DEN_W-1:0] den_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [REM_W-1:0] sub;
    logic [REM_W-1:0] rem_d;
    logic [QUO_W-1:0] quo_d;

    // Stage inputs come from the ports or from the previous stage.
    if (s == 0) begin : g_first
      assign rem_in = REM_W'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // Try to subtract the shifted divisor for this quotient bit.
    always_comb begin
      sub   = REM_W'(den_in) << (QUO_W - 1 - s);
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= sub) begin
        rem_d                  = rem_in - sub;
        quo_d[QUO_W - 1 - s]   = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= quo_d;
      end
    end

    if (s < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= rem_d;
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// ===== design/line_and_color_sensor_fusion.sv =====
// ----------------------------------------------------------------------------
// Line and color sensor fusion
// Darkness fractions, line width and centroid, and surface color class.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on the s_axis channel: four photodiode samples and
//   four color counts packed in s_axis_tdata. Each request yields exactly one
//   result on the m_axis channel: position, width and color in m_axis_tdata
//   and the line-lost flag in m_axis_tuser.
//   Calibration levels are written through cfg_we_i / cfg_index_i /
//   cfg_data_i while no request is in flight.
//   The front dividers resolve one quotient bit per stage, as does the
//   centroid divider, and those two chains set the depth.
//   Throughput is one request per cycle while the receiver takes results.
//   Reset empties the pipeline and restores the default calibration levels.
//   When the receiver stalls, the whole pipeline holds its contents and
//   s_axis_tready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_and_color_sensor_fusion_defines.svh"

module line_and_color_sensor_fusion #(
  parameter int SAMPLE_BITS   = 10,
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  // Fields from bit 0 up: left_outer_sample, left_inner_sample,
  // right_inner_sample, right_outer_sample, red_count, green_count,
  // blue_count, white_count.
  input  wire logic                                             s_axis_tvalid,
  output logic                                                  s_axis_tready,
  input  wire logic [((4*SAMPLE_BITS + 4*COUNT_BITS + 7)/8)*8-1:0] s_axis_tdata,

  // Fields from bit 0 up: line_position, line_width, surface_color.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [lcsf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // Field: line_lost.
  output logic                               m_axis_tuser,

  input  wire logic                              cfg_we_i,
  input  wire logic [lcsf_pkg::LEVEL_IDX_W-1:0]  cfg_index_i,
  input  wire logic [SAMPLE_BITS-1:0]            cfg_data_i
);

  localparam int S       = SAMPLE_BITS;
  localparam int C       = COUNT_BITS;
  localparam int F       = FRACTION_BITS;
  localparam int IN_BITS = 4 * S + 4 * C;
  localparam int ND      = lcsf_pkg::NUM_DIODES;
  localparam int NR      = lcsf_pkg::NUM_RATIOS;
  localparam int NC      = lcsf_pkg::NUM_CLASSES;
  localparam int NT      = lcsf_pkg::NUM_TERMS;
  localparam int DIV_QW  = (F + 1 > lcsf_pkg::RATIO_W) ? F + 1 : lcsf_pkg::RATIO_W;
  localparam int DNUM_W  = S + F;
  localparam int PROD_W  = C + lcsf_pkg::SCALE_W;
  localparam int SATC_W  = (PROD_W > C + DIV_QW) ? PROD_W : C + DIV_QW;
  localparam int WX_W    = (C > lcsf_pkg::WLEVEL_W) ? C : lcsf_pkg::WLEVEL_W;
  localparam int DK_W    = F + 1;
  localparam int X_W     = C + 9;
  localparam int PRD_W   = lcsf_pkg::WGT_W + X_W;
  localparam int SCORE_W = PRD_W + 3;
  localparam int NW      = F + 3;
  localparam int GEO_W   = 3 * NW;
  localparam int SIDE_W  = ND + NR + 1 + C + DK_W;
  localparam int L10_W   = F + 7;
  localparam int PQ_W    = F + 2;
  localparam int PNUM_W  = 2 * F + 2;
  localparam int PSIDE_W = lcsf_pkg::COLOR_W + NW + 2;
  localparam int NSTG    = DIV_QW + F + 13;
  // Reciprocal of the white-channel span, exact for every span offset.
  localparam int WREC_SH = 27;
  localparam int WREC_W  = F + 14;
  localparam longint unsigned WREC =
    ((64'd1 << (WREC_SH + F)) + lcsf_pkg::COLOR_SPAN - 1) / lcsf_pkg::COLOR_SPAN;
  localparam int WP_W    = lcsf_pkg::SPAN_W + WREC_W;

  // Pipeline advance: everything moves unless a result waits unclaimed.
  logic adv;
  logic [NSTG-1:0] vld_q;

  assign adv           = !vld_q[NSTG-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
    end
  end

  // Calibration level registers.
  logic [S-1:0] lvl_q [lcsf_pkg::NUM_LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lcsf_pkg::NUM_LEVELS; k++) begin
        lvl_q[k] <= S'(lcsf_pkg::LEVEL_RESET[k]);
      end
    end else if (cfg_we_i) begin
      lvl_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Stage 1: capture the request.
  logic [S-1:0] smp1_q [ND];
  logic [C-1:0] cnt1_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < ND; i++) begin
        smp1_q[i] <= s_axis_tdata[i*S +: S];
      end
      for (int j = 0; j < 4; j++) begin
        cnt1_q[j] <= s_axis_tdata[4*S + j*C +: C];
      end
    end
  end

  // Stage 2: darkness bounds, ratio products and white-channel setup.
  logic [ND-1:0]     one2_d, one2_q;
  logic [DNUM_W-1:0] dnum2_d [ND];
  logic [DNUM_W-1:0] dnum2_q [ND];
  logic [S-1:0]      dden2_d [ND];
  logic [S-1:0]      dden2_q [ND];
  logic [PROD_W-1:0] prod2_d [NR];
  logic [PROD_W-1:0] prod2_q [NR];
  logic [C-1:0]      w2_q;
  logic              wone2_d, wone2_q;
  logic [lcsf_pkg::SPAN_W-1:0] wspan2_d, wspan2_q;
  logic [WX_W-1:0]   wx2;

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      logic [S-1:0] blk;
      logic [S-1:0] wht;
      logic         dv;
      blk = lvl_q[2*i];
      wht = lvl_q[2*i+1];
      one2_d[i] = (smp1_q[i] < blk) || ((smp1_q[i] <= wht) && (wht == blk));
      dv        = !one2_d[i] && (smp1_q[i] <= wht);
      dnum2_d[i] = dv ? (DNUM_W'(wht - smp1_q[i]) << F) : '0;
      dden2_d[i] = dv ? (wht - blk) : S'(1);
    end
    for (int j = 0; j < NR; j++) begin
      prod2_d[j] = PROD_W'(cnt1_q[j]) * PROD_W'(lcsf_pkg::RATIO_SCALE);
    end
    wx2     = WX_W'(cnt1_q[3]);
    wone2_d = wx2 < WX_W'(lcsf_pkg::COLOR_BLACK_LEVEL);
    if (wone2_d || (wx2 > WX_W'(lcsf_pkg::COLOR_WHITE_LEVEL))) begin
      wspan2_d = '0;
    end else begin
      wspan2_d = lcsf_pkg::SPAN_W'(WX_W'(lcsf_pkg::COLOR_WHITE_LEVEL) - wx2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      one2_q   <= one2_d;
      dnum2_q  <= dnum2_d;
      dden2_q  <= dden2_d;
      prod2_q  <= prod2_d;
      w2_q     <= cnt1_q[3];
      wone2_q  <= wone2_d;
      wspan2_q <= wspan2_d;
    end
  end

  // Stage 3: ratio saturation check and white darkness by reciprocal.
  logic [ND-1:0]     one3_q;
  logic [DNUM_W-1:0] dnum3_q [ND];
  logic [S-1:0]      dden3_q [ND];
  logic [NR-1:0]     sat3_d, sat3_q;
  logic [PROD_W-1:0] rnum3_d [NR];
  logic [PROD_W-1:0] rnum3_q [NR];
  logic [C-1:0]      w3_q;
  logic              wone3_q;
  logic [WP_W-1:0]   wprod3;
  logic [DK_W-1:0]   wd3_d, wd3_q;

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      sat3_d[j]  = (w2_q == '0) ||
                   (SATC_W'(prod2_q[j]) >= (SATC_W'(w2_q) << DIV_QW));
      rnum3_d[j] = sat3_d[j] ? '0 : prod2_q[j];
    end
    wprod3 = WP_W'(wspan2_q) * WP_W'(WREC);
    wd3_d  = DK_W'(wprod3 >> WREC_SH);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      one3_q  <= one2_q;
      dnum3_q <= dnum2_q;
      dden3_q <= dden2_q;
      sat3_q  <= sat3_d;
      rnum3_q <= rnum3_d;
      w3_q    <= w2_q;
      wone3_q <= wone2_q;
      wd3_q   <= wd3_d;
    end
  end

  // Front dividers: diode fractions and color ratios.
  logic [DIV_QW-1:0] dq [ND];
  logic [DIV_QW-1:0] rq [NR];

  for (genvar i = 0; i < ND; i++) begin : g_ddiv
    lcsf_div #(.NUM_W(DNUM_W), .DEN_W(S), .QUO_W(DIV_QW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (dnum3_q[i]),
      .den_i (dden3_q[i]),
      .quo_o (dq[i])
    );
  end

  for (genvar j = 0; j < NR; j++) begin : g_rdiv
    lcsf_div #(.NUM_W(PROD_W), .DEN_W(C), .QUO_W(DIV_QW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (rnum3_q[j]),
      .den_i (w3_q),
      .quo_o (rq[j])
    );
  end

  // Side data that travels alongside the front dividers.
  logic [SIDE_W-1:0] sd_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= {wd3_q, w3_q, wone3_q, sat3_q, one3_q};
      for (int k = 1; k < DIV_QW; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // Stage D1: finished darkness fractions and saturated ratios.
  logic [DK_W-1:0]      wd_side;
  logic [C-1:0]         w_side;
  logic                 wone_side;
  logic [NR-1:0]        sat_side;
  logic [ND-1:0]        one_side;
  logic [DK_W-1:0]      dark_q [ND];
  logic [DK_W-1:0]      wd_q;
  logic [lcsf_pkg::RATIO_W-1:0] ratio_q [NR];
  logic [C-1:0]         wd1_q;

  assign {wd_side, w_side, wone_side, sat_side, one_side} = sd_q[DIV_QW-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < ND; i++) begin
        dark_q[i] <= one_side[i] ? {1'b1, F'(0)} : dq[i][DK_W-1:0];
      end
      for (int j = 0; j < NR; j++) begin
        ratio_q[j] <= (sat_side[j] || (DIV_QW'(rq[j]) > DIV_QW'(lcsf_pkg::RATIO_MAX))) ?
                      lcsf_pkg::RATIO_W'(lcsf_pkg::RATIO_MAX) : rq[j][lcsf_pkg::RATIO_W-1:0];
      end
      wd_q  <= wone_side ? {1'b1, F'(0)} : wd_side;
      wd1_q <= w_side;
    end
  end

  // Stage D2: classifier products, centroid numerator and width sums.
  logic signed [X_W-1:0]   xin [NT];
  logic signed [PRD_W-1:0] prd_d [NC][NT];
  logic signed [PRD_W-1:0] prd_q [NC][NT];
  logic signed [NW-1:0]    ds [ND];
  logic signed [NW-1:0]    num2;
  logic [NW-1:0]           wn2;
  logic [NW-1:0]           wc2;
  logic [GEO_W-1:0]        geo_q [4];

  always_comb begin
    for (int j = 0; j < NR; j++) begin
      xin[j] = signed'(X_W'(ratio_q[j]));
    end
    xin[3] = signed'(X_W'({wd1_q, 8'b0}));
    for (int c = 0; c < NC; c++) begin
      for (int i = 0; i < NT; i++) begin
        prd_d[c][i] = PRD_W'(lcsf_pkg::CLASS_WEIGHT[c][i]) * PRD_W'(xin[i]);
      end
    end
    for (int i = 0; i < ND; i++) begin
      ds[i] = signed'(NW'(dark_q[i]));
    end
    num2 = (ds[3] <<< 1) + ds[2] - ds[1] - (ds[0] <<< 1);
    wn2  = NW'(dark_q[0]) + NW'(dark_q[1]) + NW'(dark_q[2]) + NW'(dark_q[3]);
    wc2  = wn2 + NW'(wd_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prd_q    <= prd_d;
      geo_q[0] <= {num2, wn2, wc2};
      for (int k = 1; k < 4; k++) begin
        geo_q[k] <= geo_q[k-1];
      end
    end
  end

  // Stage D3: class scores.
  logic signed [SCORE_W-1:0] score_d [NC];
  logic signed [SCORE_W-1:0] score_q [NC];

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      score_d[c] = (SCORE_W'(lcsf_pkg::CLASS_BIAS[c]) <<< lcsf_pkg::BIAS_SHIFT) +
                   SCORE_W'(prd_q[c][0]) + SCORE_W'(prd_q[c][1]) +
                   SCORE_W'(prd_q[c][2]) + SCORE_W'(prd_q[c][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      score_q <= score_d;
    end
  end

  // Stages D4 to D6: argmax tree, the lower class wins a tie.
  logic signed [SCORE_W-1:0] b01_q, b23_q, s4a_q, b03_q, s4b_q;
  lcsf_pkg::color_e          c01_q, c23_q, c03_q, color6_q;
  logic [NW-1:0]             width6_q;
  logic signed [NW-1:0]      num6_q;
  logic signed [NW-1:0]      num_g;
  logic [NW-1:0]             wn_g;
  logic [NW-1:0]             wc_g;
  lcsf_pkg::color_e          color6_d;

  assign {num_g, wn_g, wc_g} = geo_q[3];

  always_comb begin
    if (s4b_q > b03_q) begin
      color6_d = lcsf_pkg::SURF_BLUE;
    end else begin
      color6_d = c03_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (score_q[1] > score_q[0]) begin
        b01_q <= score_q[1];
        c01_q <= lcsf_pkg::SURF_BLACK;
      end else begin
        b01_q <= score_q[0];
        c01_q <= lcsf_pkg::SURF_WHITE;
      end
      if (score_q[3] > score_q[2]) begin
        b23_q <= score_q[3];
        c23_q <= lcsf_pkg::SURF_GREEN;
      end else begin
        b23_q <= score_q[2];
        c23_q <= lcsf_pkg::SURF_RED;
      end
      s4a_q <= score_q[4];

      if (b23_q > b01_q) begin
        b03_q <= b23_q;
        c03_q <= c23_q;
      end else begin
        b03_q <= b01_q;
        c03_q <= c01_q;
      end
      s4b_q <= s4a_q;

      color6_q <= color6_d;
      width6_q <= (color6_d != lcsf_pkg::SURF_WHITE) ? wc_g : wn_g;
      num6_q   <= num_g;
    end
  end

  // Stage E2: lost check and centroid magnitude.
  logic              lost7_q, neg7_q;
  logic [PQ_W-1:0]   mag7_q;
  logic [NW-1:0]     width7_q;
  lcsf_pkg::color_e  color7_q;
  logic [L10_W-1:0]  w10;

  assign w10 = (L10_W'(width6_q) << 3) + (L10_W'(width6_q) << 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lost7_q  <= w10 < (L10_W'(3) << F);
      neg7_q   <= num6_q < 0;
      mag7_q   <= PQ_W'((num6_q < 0) ? -num6_q : num6_q);
      width7_q <= width6_q;
      color7_q <= color6_q;
    end
  end

  // Centroid divider.
  logic [PQ_W-1:0]    pq;
  logic [PNUM_W-1:0]  pnum;
  logic [NW-1:0]      pden;

  assign pnum = lost7_q ? '0 : {mag7_q, F'(0)};
  assign pden = lost7_q ? NW'(1) : width7_q;

  lcsf_div #(.NUM_W(PNUM_W), .DEN_W(NW), .QUO_W(PQ_W)) u_pdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (pnum),
    .den_i (pden),
    .quo_o (pq)
  );

  logic [PSIDE_W-1:0] pd_q [PQ_W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pd_q[0] <= {color7_q, width7_q, lost7_q, neg7_q};
      for (int k = 1; k < PQ_W; k++) begin
        pd_q[k] <= pd_q[k-1];
      end
    end
  end

  // Output register: apply the centroid sign.
  logic [lcsf_pkg::COLOR_W-1:0] color_p;
  logic [NW-1:0]                width_p;
  logic                         lost_p, neg_p;
  logic signed [NW-1:0]         magx;
  logic signed [NW-1:0]         posx;
  logic [lcsf_pkg::POS_W-1:0]   pos_q;
  logic [lcsf_pkg::WID_W-1:0]   wid_q;
  logic [lcsf_pkg::COLOR_W-1:0] color_q;
  logic                         lost_q;

  assign {color_p, width_p, lost_p, neg_p} = pd_q[PQ_W-1];
  assign magx = signed'(NW'(pq));
  assign posx = neg_p ? -magx : magx;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q   <= lcsf_pkg::POS_W'(posx);
      wid_q   <= lcsf_pkg::WID_W'(width_p);
      color_q <= color_p;
      lost_q  <= lost_p;
    end
  end

  assign m_axis_tdata = {
    (lcsf_pkg::OUT_DATA_W - lcsf_pkg::POS_W - lcsf_pkg::WID_W - lcsf_pkg::COLOR_W)'(0),
    color_q, wid_q, pos_q
  };
  assign m_axis_tuser = lost_q;

  // Assertions.
  `LCSF_ASSERT_IMPL(a_lost_pos_zero, clk_i, rst_ni, m_axis_tvalid && lost_q,
    pos_q == '0, "lost line with nonzero position")
  `LCSF_ASSERT_IMPL(a_found_width, clk_i, rst_ni, m_axis_tvalid && !lost_q,
    wid_q != '0, "found line with zero width")
  `LCSF_ASSERT_IMPL(a_stall_blocks, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    !s_axis_tready, "input taken during output stall")
  `LCSF_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    vld_q[0], "accepted request not in first stage")

endmodule

`default_nettype wire
